// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the run-length encoder RTL.
// Needs nothing else; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BMR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("run-length encoder check failed");

// Next-cycle implication, disabled while reset is high.
`define BMR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("run-length encoder check failed");

`endif

// ===== rtl/bmr_pkg.sv =====
// Package of the bit map run-length encoder: sizes, run and batch types, saturation.
// Depends on nothing; used by bmr_scan.sv, bmr_drain.sv and the core.
`timescale 1ns / 1ps

package bmr_pkg;

  // Map geometry and run length limit.
  localparam int MAP_BYTES     = 1024;
  localparam int BITS_PER_BYTE = 8;
  localparam int LEN_W         = 14;
  localparam int LEN_CAP       = 16383;
  localparam int RUN_MAX_I     = (MAP_BYTES * BITS_PER_BYTE > LEN_CAP) ?
                                 LEN_CAP : MAP_BYTES * BITS_PER_BYTE;
  localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'(RUN_MAX_I);

  // One byte can close up to eight runs, plus the final run of the map.
  localparam int MAX_RUNS = BITS_PER_BYTE + 1;
  localparam int CNT_W    = 4;

  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic             run_value;
    logic             last_run;
  } run_t;

  // All runs produced by one byte, in output order.
  typedef struct packed {
    run_t [MAX_RUNS-1:0] runs;
    logic [CNT_W-1:0]    count;
  } batch_t;

  // Length plus a small increment, held at the maximum run length.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W:0] sum);
    logic [LEN_W-1:0] res;
    res = (sum > {1'b0, RUN_MAX}) ? RUN_MAX : sum[LEN_W-1:0];
    return res;
  endfunction

endpackage

// ===== rtl/bmr_if.sv =====
// Valid/ready channel interfaces of the bit map run-length encoder.
// Depends on nothing; the map byte channel and the run channel.
`timescale 1ns / 1ps

interface bmr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] map_byte;
  logic       last_byte;

  modport source (output valid, output map_byte, output last_byte, input ready);
  modport sink   (input valid, input map_byte, input last_byte, output ready);
endinterface

interface bmr_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] run_length;
  logic        run_value;
  logic        last_run;

  modport source (output valid, output run_length, output run_value, output last_run,
                  input ready);
  modport sink   (input valid, input run_length, input run_value, input last_run,
                  output ready);
endinterface

// ===== rtl/bmr_scan.sv =====
// Input register, open-run state and the single-pass run finder for one map byte.
// Depends on bmr_pkg, bmr_if.sv and assert_macros.svh.
`timescale 1ns / 1ps

module bmr_scan (
  input  logic           clk,
  input  logic           rst,
  bmr_in_if.sink         map_in,
  output bmr_pkg::batch_t batch,
  output logic           batch_valid,
  input  logic           batch_ready
);
  import bmr_pkg::*;

  `include "assert_macros.svh"

  logic                     in_valid;
  logic [BITS_PER_BYTE-1:0] in_byte;
  logic                     in_last;
  logic                     started;
  logic                     cur_val;
  logic [LEN_W-1:0]         cur_len;

  logic                     fire;
  logic                     started_next;
  logic                     cur_val_next;
  logic [LEN_W-1:0]         cur_len_next;

  logic                     prev_bit;
  logic                     this_bit;
  logic [LEN_W-1:0]         carry;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         start_pos;
  logic [CNT_W-1:0]         first_pos;
  logic [LEN_W-1:0]         tail_len;

  assign fire         = in_valid && batch_ready;
  assign batch_valid  = in_valid;
  assign map_in.ready = !in_valid || fire;

  // Input register: holds one byte until the batch stage takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (map_in.ready) begin
      in_valid <= map_in.valid;
    end
    if (map_in.ready && map_in.valid) begin
      in_byte <= map_in.map_byte;
      in_last <= map_in.last_byte;
    end
  end

  // Find every value change in the byte and the runs it closes.
  always_comb begin
    batch     = '0;
    k         = '0;
    start_pos = '0;
    first_pos = '0;
    carry     = started ? cur_len : '0;
    prev_bit  = started ? cur_val : in_byte[0];
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      this_bit = in_byte[i];
      if (this_bit != prev_bit) begin
        if (k == '0) begin
          first_pos = CNT_W'(i);
        end
        batch.runs[k].run_length = LEN_W'(CNT_W'(i) - start_pos);
        batch.runs[k].run_value  = prev_bit;
        batch.runs[k].last_run   = 1'b0;
        k         = k + CNT_W'(1);
        start_pos = CNT_W'(i);
      end
      prev_bit = this_bit;
    end
    // The first closed run continues the run left open by earlier bytes.
    if (k != '0) begin
      batch.runs[0].run_length = sat_len({1'b0, carry} + (LEN_W + 1)'(first_pos));
      tail_len = LEN_W'(CNT_W'(BITS_PER_BYTE) - start_pos);
    end else begin
      tail_len = sat_len({1'b0, carry} + (LEN_W + 1)'(BITS_PER_BYTE));
    end
    // The open run goes out as the final one on the last byte.
    if (in_last) begin
      batch.runs[k].run_length = tail_len;
      batch.runs[k].run_value  = in_byte[BITS_PER_BYTE-1];
      batch.runs[k].last_run   = 1'b1;
      k = k + CNT_W'(1);
    end
    batch.count = k;
  end

  // Open-run state after this byte; a map end returns to the start state.
  always_comb begin
    if (in_last) begin
      started_next = 1'b0;
      cur_val_next = 1'b0;
      cur_len_next = '0;
    end else begin
      started_next = 1'b1;
      cur_val_next = in_byte[BITS_PER_BYTE-1];
      cur_len_next = tail_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      cur_val <= 1'b0;
      cur_len <= '0;
    end else if (fire) begin
      started <= started_next;
      cur_val <= cur_val_next;
      cur_len <= cur_len_next;
    end
  end

  // The open run is empty exactly when no run is open, and never exceeds the cap.
  `BMR_ASSERT_NOW(a_idle_len, clk, rst, !started, cur_len == '0)
  `BMR_ASSERT_NOW(a_open_len, clk, rst, started, (cur_len != '0) && (cur_len <= RUN_MAX))
  `BMR_ASSERT_NEXT(a_map_end, clk, rst, fire && in_last, !started)
  `BMR_ASSERT_NOW(a_batch_cnt, clk, rst, in_valid, batch.count <= CNT_W'(MAX_RUNS))

endmodule

// ===== rtl/bmr_drain.sv =====
// Batch register that holds the runs of one byte and sends them one beat at a time.
// Depends on bmr_pkg, bmr_if.sv and assert_macros.svh.
`timescale 1ns / 1ps

module bmr_drain (
  input  logic            clk,
  input  logic            rst,
  input  bmr_pkg::batch_t batch_in,
  input  logic            batch_valid,
  output logic            batch_ready,
  bmr_out_if.source       run_out
);
  import bmr_pkg::*;

  `include "assert_macros.svh"

  logic             held;
  run_t [MAX_RUNS-1:0] runs;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;

  logic             out_fire;
  logic             at_end;
  logic             load;
  run_t             cur_run;

  assign out_fire    = held && run_out.ready;
  assign at_end      = (idx == count - CNT_W'(1));
  assign batch_ready = !held || (out_fire && at_end);
  assign load        = batch_valid && batch_ready && (batch_in.count != '0);

  assign cur_run            = runs[idx];
  assign run_out.valid      = held;
  assign run_out.run_length = cur_run.run_length;
  assign run_out.run_value  = cur_run.run_value;
  assign run_out.last_run   = cur_run.last_run;

  // Load a new batch when the old one is gone or leaves with this beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      held <= 1'b1;
      idx  <= '0;
    end else if (out_fire) begin
      if (at_end) begin
        held <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + CNT_W'(1);
      end
    end
    if (load) begin
      runs  <= batch_in.runs;
      count <= batch_in.count;
    end
  end

  // A held batch is never empty and the read index stays inside it.
  `BMR_ASSERT_NOW(a_held_cnt, clk, rst, held, (count != '0) && (idx < count))
  `BMR_ASSERT_NEXT(a_keep_batch, clk, rst, out_fire && !at_end, held)
  `BMR_ASSERT_NOW(a_last_at_end, clk, rst, held && cur_run.last_run, at_end)

endmodule

// ===== rtl/bit_map_run_length_encoder_core.sv =====
// Bit map run-length encoder: takes map bytes, bit 0 first, and gives runs of equal bits.
// An input byte is taken every cycle while each byte yields at most one run and the run port
// is ready. A byte that yields n runs (up to eight value changes, plus the final run on the
// byte marked last) sends them one by one on the single run port; the byte behind it waits in
// the input register. A byte passes the input and batch registers before its first run
// goes out. Run lengths saturate at MAP_BYTES*8 held to 16383; after the last byte the block
// is back in its start state. Depends on bmr_pkg, bmr_if.sv, bmr_scan and bmr_drain.
`timescale 1ns / 1ps

module bit_map_run_length_encoder_core (
  input  logic      clk,
  input  logic      rst,
  bmr_in_if.sink    map_in,
  bmr_out_if.source run_out
);
  import bmr_pkg::*;

  batch_t batch;
  logic   batch_valid;
  logic   batch_ready;

  // Input register and run finder.
  bmr_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .map_in      (map_in),
    .batch       (batch),
    .batch_valid (batch_valid),
    .batch_ready (batch_ready)
  );

  // Batch register and run output.
  bmr_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .batch_in    (batch),
    .batch_valid (batch_valid),
    .batch_ready (batch_ready),
    .run_out     (run_out)
  );

endmodule
